@@ rtl/core/i6w_pkg.sv @@
// shared constants, types and helpers of the ipv6 extension header walker
package i6w_pkg;

  localparam logic [4:0]  MAX_EXT_HEADERS = 5'd16;
  localparam logic [15:0] FIXED_LEN       = 16'd40;
  localparam logic [3:0]  IP_VERSION      = 4'd6;

  localparam logic [7:0] PROTO_HOP      = 8'd0;
  localparam logic [7:0] PROTO_ROUTING  = 8'd43;
  localparam logic [7:0] PROTO_FRAGMENT = 8'd44;
  localparam logic [7:0] PROTO_DSTOPTS  = 8'd60;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_SHORT       = 2'd1;
  localparam logic [1:0] STATUS_BAD_VERSION = 2'd2;

  localparam int OUT_DATA_W = 336;

  // fixed header fields as they stand after the current byte
  typedef struct packed {
    logic        bad_version;
    logic [15:0] pay_len;
    logic [7:0]  nxt_hdr;
    logic [7:0]  hop_lim;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
  } i6w_fixed_t;

  // walk state as it stands after the current byte
  typedef struct packed {
    logic        in_body;
    logic [15:0] header_end;
    logic [7:0]  proto;
    logic [15:0] walked;
    logic        fragmented;
  } i6w_walk_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] pay_len;
    logic [7:0]  first_nxt_hdr;
    logic [7:0]  hop_lim;
    logic [7:0]  upper_proto;
    logic [15:0] ext_bytes;
    logic [15:0] consumed_bytes;
    logic        fragmented;
    logic [63:0] source_high;
    logic [63:0] source_low;
    logic [63:0] dest_high;
    logic [63:0] dest_low;
  } i6w_summary_t;

  function automatic logic walkable(input logic [7:0] p);
    return (p == PROTO_HOP) || (p == PROTO_ROUTING) ||
           (p == PROTO_DSTOPTS) || (p == PROTO_FRAGMENT);
  endfunction

endpackage

@@ rtl/core/i6w_hdr_capture.sv @@
// byte offset counter and capture of the fixed 40-byte ipv6 header
module i6w_hdr_capture (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  output logic [15:0]        offset,
  output i6w_pkg::i6w_fixed_t fixed_o
);

  logic [15:0] offset_r, offset_nxt;
  logic        bad_r, bad_nxt;
  logic [31:0] fields_r, fields_nxt;
  logic [63:0] addr_r [4];
  logic [63:0] addr_nxt [4];
  logic [1:0]  word_idx;

  assign word_idx = 2'(offset_r[4:3] - 2'd1);

  always_comb begin
    bad_nxt    = bad_r;
    fields_nxt = fields_r;
    addr_nxt   = addr_r;
    if (offset_r == 16'd0) begin
      bad_nxt = (in_byte[7:4] != i6w_pkg::IP_VERSION);
    end
    if (offset_r >= 16'd4 && offset_r <= 16'd7) begin
      case (offset_r[1:0])
        2'd0:    fields_nxt[31:24] = in_byte;
        2'd1:    fields_nxt[23:16] = in_byte;
        2'd2:    fields_nxt[15:8]  = in_byte;
        default: fields_nxt[7:0]   = in_byte;
      endcase
    end
    if (offset_r >= 16'd8 && offset_r < i6w_pkg::FIXED_LEN) begin
      addr_nxt[word_idx] = {addr_r[word_idx][55:0], in_byte};
    end
  end

  // offset saturates so oversized packets still end cleanly
  always_comb begin
    offset_nxt = offset_r;
    if (take) begin
      if (in_last) begin
        offset_nxt = '0;
      end else if (offset_r != 16'hFFFF) begin
        offset_nxt = offset_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else begin
      offset_r <= offset_nxt;
    end
  end

  // every field is rewritten before a packet can report it
  always_ff @(posedge clk) begin
    if (take) begin
      bad_r    <= bad_nxt;
      fields_r <= fields_nxt;
      addr_r   <= addr_nxt;
    end
  end

  assign offset              = offset_r;
  assign fixed_o.bad_version = bad_nxt;
  assign fixed_o.pay_len     = fields_nxt[31:16];
  assign fixed_o.nxt_hdr     = fields_nxt[15:8];
  assign fixed_o.hop_lim     = fields_nxt[7:0];
  assign fixed_o.src_hi      = addr_nxt[0];
  assign fixed_o.src_lo      = addr_nxt[1];
  assign fixed_o.dst_hi      = addr_nxt[2];
  assign fixed_o.dst_lo      = addr_nxt[3];

endmodule

@@ rtl/core/i6w_ext_walker.sv @@
// extension header walk: tracks header boundaries and the protocol chain
module i6w_ext_walker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  input  logic [15:0]        offset,
  input  logic [7:0]         first_nh,
  output i6w_pkg::i6w_walk_t walk_o
);

  typedef enum logic [1:0] {PH_FIXED, PH_START, PH_INSIDE, PH_DONE} phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] hend_r, hend_nxt;
  logic [7:0]  cur_r, cur_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [15:0] walked_r, walked_nxt;
  logic [4:0]  count_r, count_nxt;
  logic        frag_r, frag_nxt;
  logic [11:0] hlen;
  logic [16:0] offset_ext;
  logic [16:0] hend_ext;

  function automatic phase_t pick_phase(input logic [7:0] p, input logic [4:0] cnt);
    if (i6w_pkg::walkable(p) && cnt < i6w_pkg::MAX_EXT_HEADERS) begin
      return PH_START;
    end
    return PH_DONE;
  endfunction

  assign offset_ext = {1'b0, offset};
  assign hend_ext   = {1'b0, hend_r};
  // fragment headers are fixed size, the others carry (len+1)*8
  assign hlen = (cur_r == i6w_pkg::PROTO_FRAGMENT) ? 12'd8
                                                   : {({1'b0, in_byte} + 9'd1), 3'b000};

  always_comb begin
    phase_nxt  = phase_r;
    hend_nxt   = hend_r;
    cur_nxt    = cur_r;
    pend_nxt   = pend_r;
    walked_nxt = walked_r;
    count_nxt  = count_r;
    frag_nxt   = frag_r;
    case (phase_r)
      PH_FIXED: begin
        if (offset == i6w_pkg::FIXED_LEN - 16'd1) begin
          cur_nxt   = first_nh;
          hend_nxt  = i6w_pkg::FIXED_LEN;
          phase_nxt = pick_phase(first_nh, count_r);
        end
      end
      PH_START: begin
        if (offset == hend_r) begin
          pend_nxt = in_byte;
        end else if (offset_ext == hend_ext + 17'd1) begin
          if (cur_r == i6w_pkg::PROTO_FRAGMENT) begin
            frag_nxt = 1'b1;
          end
          hend_nxt  = hend_r + {4'b0, hlen};
          phase_nxt = PH_INSIDE;
        end
      end
      PH_INSIDE: begin
        if (offset_ext + 17'd1 == hend_ext) begin
          walked_nxt = hend_r - i6w_pkg::FIXED_LEN;
          cur_nxt    = pend_r;
          count_nxt  = count_r + 5'd1;
          phase_nxt  = pick_phase(pend_r, count_r + 5'd1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && in_last)) begin
      phase_r  <= PH_FIXED;
      hend_r   <= i6w_pkg::FIXED_LEN;
      cur_r    <= '0;
      pend_r   <= '0;
      walked_r <= '0;
      count_r  <= '0;
      frag_r   <= 1'b0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      hend_r   <= hend_nxt;
      cur_r    <= cur_nxt;
      pend_r   <= pend_nxt;
      walked_r <= walked_nxt;
      count_r  <= count_nxt;
      frag_r   <= frag_nxt;
    end
  end

  assign walk_o.in_body    = (phase_nxt == PH_INSIDE);
  assign walk_o.header_end = hend_nxt;
  assign walk_o.proto      = cur_nxt;
  assign walk_o.walked     = walked_nxt;
  assign walk_o.fragmented = frag_nxt;

endmodule

@@ rtl/core/i6w_out_skid.sv @@
// result register with a skid stage so input keeps flowing under a stall
module i6w_out_skid (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  res_valid,
  input  i6w_pkg::i6w_summary_t res,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i6w_pkg::i6w_summary_t out_data
);

  logic                  out_v_r;
  logic                  skid_v_r;
  i6w_pkg::i6w_summary_t out_r;
  i6w_pkg::i6w_summary_t skid_r;
  logic                  out_free;

  assign out_free = !out_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      // skid drains first; no new result can arrive while it is full
      out_v_r  <= skid_v_r || res_valid;
      skid_v_r <= 1'b0;
    end else if (res_valid) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_v_r ? skid_r : res;
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign in_ready  = !skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

@@ rtl/core/ipv6_header_ext_walker.sv @@
// top level: ipv6 fixed header capture and extension header walk
//
// in_* carries one packet byte per transfer in wire order, in_tlast on the
// final byte. out_* carries one summary per packet: status in out_tuser,
// header fields, transport protocol, walked extension bytes, consumed
// offset, fragment flag and both addresses in out_tdata.
// The capture and walk logic take each byte as it transfers; the summary
// is registered in the output register, or parks in the skid register
// while the receiver stalls. Throughput is one byte per cycle with no gap
// between packets, while in_tready is high.
// Reset clears the byte counter, the walk state and both output stages;
// the block is ready for a packet on the first cycle after reset.
// When the receiver stalls, the waiting summary holds in the output
// register and bytes keep flowing; a second finished summary parks in a
// skid register, and in_tready drops only while that skid register is full.
module ipv6_header_ext_walker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // packet_byte
  input  logic                              in_tlast,   // last_byte
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // pay_len, first_nxt_hdr, hop_lim, upper_proto, ext_bytes,
  // consumed_bytes, fragmented, source_high, source_low, dest_high,
  // dest_low, zero fill
  output logic [i6w_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [1:0]                        out_tuser   // status
);

  logic                  take;
  logic [15:0]           offset;
  i6w_pkg::i6w_fixed_t   fixed_s;
  i6w_pkg::i6w_walk_t    walk_s;
  i6w_pkg::i6w_summary_t res;
  i6w_pkg::i6w_summary_t out_s;
  logic [15:0]           consumed;

  assign take = in_tvalid && in_tready;

  i6w_hdr_capture u_capture (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .offset  (offset),
    .fixed_o (fixed_s)
  );

  i6w_ext_walker u_walker (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .offset   (offset),
    .first_nh (fixed_s.nxt_hdr),
    .walk_o   (walk_s)
  );

  // truncated inside a header reports the packet length, saturated
  assign consumed = !walk_s.in_body     ? walk_s.header_end :
                    (offset == 16'hFFFF) ? 16'hFFFF : offset + 16'd1;

  always_comb begin
    res = '0;
    if (offset < i6w_pkg::FIXED_LEN - 16'd1) begin
      res.status = i6w_pkg::STATUS_SHORT;
    end else if (fixed_s.bad_version) begin
      res.status = i6w_pkg::STATUS_BAD_VERSION;
    end else begin
      res.status         = i6w_pkg::STATUS_OK;
      res.pay_len        = fixed_s.pay_len;
      res.first_nxt_hdr  = fixed_s.nxt_hdr;
      res.hop_lim        = fixed_s.hop_lim;
      res.upper_proto    = walk_s.proto;
      res.ext_bytes      = walk_s.walked;
      res.consumed_bytes = consumed;
      res.fragmented     = walk_s.fragmented;
      res.source_high    = fixed_s.src_hi;
      res.source_low     = fixed_s.src_lo;
      res.dest_high      = fixed_s.dst_hi;
      res.dest_low       = fixed_s.dst_lo;
    end
  end

  i6w_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (take && in_tlast),
    .res       (res),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_s)
  );

  assign out_tuser = out_s.status;
  assign out_tdata = {7'b0, out_s.dest_low, out_s.dest_high, out_s.source_low,
                      out_s.source_high, out_s.fragmented, out_s.consumed_bytes,
                      out_s.ext_bytes, out_s.upper_proto, out_s.hop_lim,
                      out_s.first_nxt_hdr, out_s.pay_len};

  // input stalls only while both output stages hold a summary
  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output register");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> out_tvalid)
    else $error("no summary after last byte transfer");

  a_error_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != i6w_pkg::STATUS_OK) |-> (out_tdata == '0))
    else $error("error summary carries nonzero fields");

endmodule
